// ===== rtl/core/mlfc_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfc_pkg
// shared types and constants for the memory lcd frame controller
// ----------------------------------------------------------------------------
package mlfc_pkg;

  localparam int LINES          = 128;
  localparam int BYTES_PER_LINE = 16;

  localparam int FRAME_BYTES  = LINES * BYTES_PER_LINE;
  localparam int PIX_PER_LINE = BYTES_PER_LINE * 8;
  localparam int ADDR_W       = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int LINE_W       = 8;
  localparam int POS_W        = $clog2(BYTES_PER_LINE + 2);

  localparam logic [7:0] BYTE_UPDATE    = 8'h01;
  localparam logic [7:0] BYTE_ALL_CLEAR = 8'h04;
  localparam logic [7:0] BYTE_DUMMY     = 8'h00;
  localparam logic [7:0] BYTE_WHITE     = 8'hFF;

  typedef enum logic [1:0] {
    CMD_DRAW    = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_REFRESH = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_IDLE       = 2'd0,
    KIND_CLEAR      = 2'd1,
    KIND_UPDATE     = 2'd2,
    KIND_UPDATE_CMD = 2'd3
  } kind_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic sweep;
  } ctrl_cmd_t;

  typedef struct packed {
    logic exec_hold;
    logic clear_go;
    logic sweep_last;
  } ctrl_sts_t;

endpackage

// ===== rtl/core/mlfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlfc_ctrl
// sequencer: clearing sweep, item accept and execute steps
// ----------------------------------------------------------------------------
module mlfc_ctrl
  import mlfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_SWEEP: begin
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (sts.clear_go) begin
          state_nxt = S_SWEEP;
        end else if (sts.exec_hold) begin
          state_nxt = S_EXEC;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_SWEEP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cmd.load  = (state_r == S_IDLE) && in_valid;
  assign cmd.exec  = (state_r == S_EXEC);
  assign cmd.sweep = (state_r == S_SWEEP);

endmodule

// ===== rtl/core/mlfc_datapath.sv =====
// ----------------------------------------------------------------------------
// mlfc_datapath
// frame memory, transfer state and output register
// ----------------------------------------------------------------------------
module mlfc_datapath
  import mlfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_cmd_t          cmd,
  output ctrl_sts_t          sts,
  input  logic [1:0]         in_command,
  input  logic signed [15:0] in_x_position,
  input  logic signed [15:0] in_y_position,
  input  logic               in_pixel_color,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_wire_byte,
  output logic               out_first_of_transfer,
  output logic               out_last_of_transfer,
  output logic               out_vcom_level
);

  logic [7:0] frame_mem [FRAME_BYTES];

  // latched item
  cmd_t              cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [2:0]        bit_r;
  logic              color_r;
  logic              inrange_r;
  logic [7:0]        rd_data_r;

  // transfer state
  kind_t             kind_r;
  kind_t             kind_nxt;
  logic [LINE_W-1:0] line_r;
  logic [LINE_W-1:0] line_nxt;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;
  logic              vcom_r;
  logic [ADDR_W-1:0] sweep_r;

  // output register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_first_r;
  logic       out_last_r;
  logic       out_vcom_r;

  logic              x_ok;
  logic              y_ok;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] line_base;
  logic              emit;
  logic              out_busy;
  logic              fire;
  logic [7:0]        em_byte;
  logic              em_first;
  logic              em_last;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [7:0]        pix_mask;

  assign x_ok = !in_x_position[15] &&
                ($unsigned(in_x_position) < 16'(PIX_PER_LINE));
  assign y_ok = !in_y_position[15] && ($unsigned(in_y_position) < 16'(LINES));

  assign line_base = ADDR_W'(ADDR_W'(line_r) * ADDR_W'(BYTES_PER_LINE));

  always_comb begin
    if (cmd_t'(in_command) == CMD_DRAW) begin
      rd_addr = ADDR_W'(ADDR_W'($unsigned(in_y_position)) * ADDR_W'(BYTES_PER_LINE)
              + ADDR_W'($unsigned(in_x_position[15:3])));
    end else begin
      rd_addr = ADDR_W'(line_base + ADDR_W'(pos_r - POS_W'(1)));
    end
  end

  assign emit     = (cmd_r == CMD_TICK) && (kind_r != KIND_IDLE);
  assign out_busy = out_valid_r && out_stall;
  assign fire     = cmd.exec && emit && !out_busy;

  always_comb begin
    em_byte  = BYTE_DUMMY;
    em_first = 1'b0;
    em_last  = 1'b0;
    kind_nxt = kind_r;
    line_nxt = line_r;
    pos_nxt  = pos_r;
    unique case (kind_r)
      KIND_CLEAR: begin
        if (pos_r == '0) begin
          em_byte  = BYTE_ALL_CLEAR;
          em_first = 1'b1;
          pos_nxt  = POS_W'(1);
        end else begin
          em_last = 1'b1;
        end
      end
      KIND_UPDATE_CMD: begin
        em_byte  = BYTE_UPDATE;
        em_first = 1'b1;
        kind_nxt = KIND_UPDATE;
        line_nxt = '0;
        pos_nxt  = '0;
      end
      KIND_UPDATE: begin
        priority if (pos_r == '0) begin
          em_byte = 8'(line_r + LINE_W'(1));
          pos_nxt = POS_W'(1);
        end else if (pos_r <= POS_W'(BYTES_PER_LINE)) begin
          em_byte = rd_data_r;
          pos_nxt = POS_W'(pos_r + POS_W'(1));
        end else if (line_r == LINE_W'(LINES - 1)) begin
          em_last = 1'b1;
        end else begin
          line_nxt = LINE_W'(line_r + LINE_W'(1));
          pos_nxt  = '0;
        end
      end
      KIND_IDLE: begin
        em_byte = BYTE_DUMMY;
      end
      default: em_byte = BYTE_DUMMY;
    endcase
    if (em_last) begin
      kind_nxt = KIND_IDLE;
      line_nxt = '0;
      pos_nxt  = '0;
    end
  end

  assign sts.exec_hold  = cmd.exec && emit && out_busy;
  assign sts.clear_go   = cmd.exec && (cmd_r == CMD_CLEAR) && (kind_r == KIND_IDLE);
  assign sts.sweep_last = (sweep_r == ADDR_W'(FRAME_BYTES - 1));

  assign pix_mask  = 8'(8'd1 << bit_r);
  assign mem_we    = cmd.sweep || (cmd.exec && (cmd_r == CMD_DRAW) && inrange_r);
  assign mem_waddr = cmd.sweep ? sweep_r : addr_r;
  always_comb begin
    priority if (cmd.sweep) begin
      mem_wdata = BYTE_WHITE;
    end else if (color_r) begin
      mem_wdata = rd_data_r | pix_mask;
    end else begin
      mem_wdata = rd_data_r & ~pix_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.load) begin
      rd_data_r <= frame_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= cmd_t'(in_command);
      addr_r    <= rd_addr;
      bit_r     <= in_x_position[2:0];
      color_r   <= in_pixel_color;
      inrange_r <= x_ok && y_ok;
    end
    if (fire) begin
      out_byte_r  <= em_byte;
      out_first_r <= em_first;
      out_last_r  <= em_last;
      out_vcom_r  <= vcom_r ^ em_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= KIND_IDLE;
      line_r      <= '0;
      pos_r       <= '0;
      vcom_r      <= 1'b0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.sweep) begin
        sweep_r <= sts.sweep_last ? '0 : ADDR_W'(sweep_r + ADDR_W'(1));
      end
      if (sts.clear_go) begin
        kind_r <= KIND_CLEAR;
        line_r <= '0;
        pos_r  <= '0;
      end else if (cmd.exec && (cmd_r == CMD_REFRESH) && (kind_r == KIND_IDLE)) begin
        kind_r <= KIND_UPDATE_CMD;
        line_r <= '0;
        pos_r  <= '0;
      end else if (fire) begin
        kind_r <= kind_nxt;
        line_r <= line_nxt;
        pos_r  <= pos_nxt;
        vcom_r <= vcom_r ^ em_last;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_wire_byte         = out_byte_r;
  assign out_first_of_transfer = out_first_r;
  assign out_last_of_transfer  = out_last_r;
  assign out_vcom_level        = out_vcom_r;

`ifndef ASSERT_OFF
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r == KIND_IDLE) |-> (line_r == '0) && (pos_r == '0))
    else $error("idle transfer with stale position");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r <= POS_W'(BYTES_PER_LINE + 1)) && (line_r < LINE_W'(LINES)))
    else $error("transfer position out of range");

  a_vcom_flip: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && em_last) |=> (vcom_r != $past(vcom_r)) && (kind_r == KIND_IDLE))
    else $error("last byte did not toggle vcom");

  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.sweep && (cmd.exec || cmd.load)))
    else $error("sweep overlaps item processing");
`endif

endmodule

// ===== rtl/core/memory_lcd_frame_controller_core.sv =====
// ----------------------------------------------------------------------------
// memory_lcd_frame_controller_core
// 1-bit memory lcd frame controller: frame buffer, draw, clear, line updates
// ----------------------------------------------------------------------------
// Each accepted item has an accept step, which reads the single port
// frame memory, and an execute step (pixel read-modify-write or emitting a
// byte). A tick that emits a byte waits in the execute step while the output
// register is full and stalled. After reset, and after a clear accepted while no
// transfer is in progress, a clearing pass writes white to all 2048 frame bytes
// (one byte a cycle) and no item is accepted meanwhile.
module memory_lcd_frame_controller_core
  import mlfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [15:0] in_x_position,
  input  logic signed [15:0] in_y_position,
  input  logic               in_pixel_color,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_wire_byte,
  output logic               out_first_of_transfer,
  output logic               out_last_of_transfer,
  output logic               out_vcom_level
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  mlfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mlfc_datapath u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_command            (in_command),
    .in_x_position         (in_x_position),
    .in_y_position         (in_y_position),
    .in_pixel_color        (in_pixel_color),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_wire_byte         (out_wire_byte),
    .out_first_of_transfer (out_first_of_transfer),
    .out_last_of_transfer  (out_last_of_transfer),
    .out_vcom_level        (out_vcom_level)
  );

endmodule
